### rtl/abc_pkg.sv
// shared types, constants and register map of the bitrate controller
`default_nettype none
package abc_pkg;

    // field widths
    localparam int RATE_W = 18;
    localparam int STEP_W = 16;
    localparam int IVAL_W = 32;
    localparam int TIME_W = 48;
    localparam int CONG_W = 12;
    localparam int DROP_W = 16;
    localparam int BAD_W  = 2;
    localparam int GOOD_W = 4;

    // stream widths (payload padded to whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;

    // config port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RATE_FLOOR        = 3'd0,
        REG_RATE_CEIL         = 3'd1,
        REG_DECREASE_STEP     = 3'd2,
        REG_INCREASE_STEP     = 3'd3,
        REG_INCREASE_INTERVAL = 3'd4
    } t_reg_idx;

    // reset values
    localparam logic [RATE_W-1:0] RATE_FLOOR_RST        = 18'd500;
    localparam logic [RATE_W-1:0] RATE_CEIL_RST         = 18'd6000;
    localparam logic [STEP_W-1:0] DECREASE_STEP_RST     = 16'd500;
    localparam logic [STEP_W-1:0] INCREASE_STEP_RST     = 16'd250;
    localparam logic [IVAL_W-1:0] INCREASE_INTERVAL_RST = 32'd1000;

    // congestion thresholds in Q2.10
    localparam logic [CONG_W-1:0] CONG_BAD_ABOVE    = 12'd512;
    localparam logic [CONG_W-1:0] CONG_GOOD_AT_MOST = 12'd102;

    // streak limits
    localparam logic [BAD_W-1:0]  BAD_CAP     = 2'd3;
    localparam logic [GOOD_W-1:0] GOOD_CAP    = 4'd15;
    localparam logic [GOOD_W-1:0] GOOD_NEEDED = 4'd10;

    // ceil(2^18 / 5): exact floor(x / 5) for every 18-bit x
    localparam int                RECIP5_SHIFT = 18;
    localparam logic [STEP_W-1:0] RECIP5       = 16'd52429;

    // signed working width for the candidate rate
    localparam int CAND_W = RATE_W + 3;

    typedef logic [RATE_W-1:0] t_rate;

    typedef enum logic [1:0] {
        DEC_STABLE   = 2'd0,
        DEC_DECREASE = 2'd1,
        DEC_INCREASE = 2'd2
    } t_decision;

    typedef struct packed {
        logic [RATE_W-1:0] rate_floor;
        logic [RATE_W-1:0] rate_ceil;
        logic [STEP_W-1:0] decrease_step;
        logic [STEP_W-1:0] increase_step;
        logic [IVAL_W-1:0] increase_interval;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [RATE_W-1:0] rate;
    } t_reload;

    typedef struct packed {
        logic [DROP_W-1:0] dropped_echo;
        logic [CONG_W-1:0] congestion_echo;
        logic [RATE_W-1:0] previous_bitrate;
        logic              rate_changed;
        t_decision         decision_code;
        logic [RATE_W-1:0] next_bitrate;
    } t_result;

endpackage
`default_nettype wire

### rtl/abc_cfg.sv
// config register file behind the apb port
`default_nettype none
module abc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [abc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [abc_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output abc_pkg::t_cfg                      o_cfg,
    output abc_pkg::t_reload                   o_reload
);

    abc_pkg::t_cfg     r_cfg;
    logic              wr_en;
    abc_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign idx    = abc_pkg::t_reg_idx'(paddr[abc_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_floor        <= abc_pkg::RATE_FLOOR_RST;
            r_cfg.rate_ceil         <= abc_pkg::RATE_CEIL_RST;
            r_cfg.decrease_step     <= abc_pkg::DECREASE_STEP_RST;
            r_cfg.increase_step     <= abc_pkg::INCREASE_STEP_RST;
            r_cfg.increase_interval <= abc_pkg::INCREASE_INTERVAL_RST;
        end else if (wr_en) begin
            case (idx)
                abc_pkg::REG_RATE_FLOOR:
                    r_cfg.rate_floor <= pwdata[abc_pkg::RATE_W-1:0];
                abc_pkg::REG_RATE_CEIL:
                    r_cfg.rate_ceil <= pwdata[abc_pkg::RATE_W-1:0];
                abc_pkg::REG_DECREASE_STEP:
                    r_cfg.decrease_step <= pwdata[abc_pkg::STEP_W-1:0];
                abc_pkg::REG_INCREASE_STEP:
                    r_cfg.increase_step <= pwdata[abc_pkg::STEP_W-1:0];
                abc_pkg::REG_INCREASE_INTERVAL:
                    r_cfg.increase_interval <= pwdata[abc_pkg::IVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // max write also reloads the running rate
    assign o_reload.load = wr_en && (idx == abc_pkg::REG_RATE_CEIL);
    assign o_reload.rate = pwdata[abc_pkg::RATE_W-1:0];
    assign o_cfg         = r_cfg;

    // read mux
    always_comb begin
        case (idx)
            abc_pkg::REG_RATE_FLOOR:
                prdata = {{(abc_pkg::APB_DATA_W-abc_pkg::RATE_W){1'b0}}, r_cfg.rate_floor};
            abc_pkg::REG_RATE_CEIL:
                prdata = {{(abc_pkg::APB_DATA_W-abc_pkg::RATE_W){1'b0}}, r_cfg.rate_ceil};
            abc_pkg::REG_DECREASE_STEP:
                prdata = {{(abc_pkg::APB_DATA_W-abc_pkg::STEP_W){1'b0}}, r_cfg.decrease_step};
            abc_pkg::REG_INCREASE_STEP:
                prdata = {{(abc_pkg::APB_DATA_W-abc_pkg::STEP_W){1'b0}}, r_cfg.increase_step};
            abc_pkg::REG_INCREASE_INTERVAL:
                prdata = r_cfg.increase_interval;
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/abc_step.sv
// controller state and the combinational rate decision
`default_nettype none
module abc_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire abc_pkg::t_cfg               i_cfg,
    input  wire abc_pkg::t_reload            i_reload,
    input  wire logic                        i_fire,
    input  wire logic [abc_pkg::CONG_W-1:0]  i_cong,
    input  wire logic [abc_pkg::DROP_W-1:0]  i_drop,
    input  wire logic [abc_pkg::TIME_W-1:0]  i_time,
    output abc_pkg::t_result                 o_result
);

    abc_pkg::t_rate                   r_rate;
    logic [abc_pkg::TIME_W-1:0]       r_last_rise;
    logic [abc_pkg::BAD_W-1:0]        r_bad;
    logic [abc_pkg::GOOD_W-1:0]       r_good;

    abc_pkg::t_rate                   n_rate;
    logic [abc_pkg::TIME_W-1:0]       n_last_rise;
    logic [abc_pkg::BAD_W-1:0]        n_bad;
    logic [abc_pkg::GOOD_W-1:0]       n_good;

    logic                             bad;
    logic                             good;
    logic                             rise;
    logic [abc_pkg::RATE_W-1:0]       dec_amt;
    logic [abc_pkg::RATE_W+abc_pkg::STEP_W-1:0] fifth_prod;
    logic [abc_pkg::STEP_W-1:0]       fifth;
    logic [abc_pkg::TIME_W-1:0]       elapsed;
    logic [abc_pkg::TIME_W-1:0]       need;
    logic signed [abc_pkg::CAND_W-1:0] cand_dec;
    logic signed [abc_pkg::CAND_W-1:0] cand_inc;
    logic signed [abc_pkg::CAND_W-1:0] cand;
    abc_pkg::t_decision               code;

    // interval classification
    assign bad  = (i_cong > abc_pkg::CONG_BAD_ABOVE) || (i_drop != '0);
    assign good = (i_cong <= abc_pkg::CONG_GOOD_AT_MOST) && (i_drop == '0);

    // saturating streak counters
    always_comb begin
        n_bad  = '0;
        n_good = '0;
        if (bad) begin
            n_bad = (r_bad == abc_pkg::BAD_CAP) ? r_bad : r_bad + 1'b1;
        end else if (good) begin
            n_good = (r_good == abc_pkg::GOOD_CAP) ? r_good : r_good + 1'b1;
        end
    end

    // decrease: step times streak plus a fifth of the rate
    assign dec_amt    = abc_pkg::RATE_W'(i_cfg.decrease_step) * abc_pkg::RATE_W'(n_bad);
    assign fifth_prod = r_rate * abc_pkg::RECIP5;
    assign fifth      = fifth_prod[abc_pkg::RECIP5_SHIFT +: abc_pkg::STEP_W];
    assign cand_dec   = $signed({3'b000, r_rate}) - $signed({3'b000, dec_amt})
                      - $signed({5'b00000, fifth});

    // increase: half a step once the good streak reaches ten and the hold-off time has passed
    assign elapsed  = i_time - r_last_rise;
    assign need     = {{(abc_pkg::TIME_W-abc_pkg::IVAL_W-1){1'b0}},
                       i_cfg.increase_interval, 1'b0};
    assign rise     = good && (n_good >= abc_pkg::GOOD_NEEDED) && (elapsed >= need);
    assign cand_inc = $signed({3'b000, r_rate})
                    + $signed({6'b000000, i_cfg.increase_step[abc_pkg::STEP_W-1:1]});

    // candidate selection and clamp (minimum tested first)
    always_comb begin
        if (bad) begin
            cand = cand_dec;
            code = abc_pkg::DEC_DECREASE;
        end else if (rise) begin
            cand = cand_inc;
            code = abc_pkg::DEC_INCREASE;
        end else begin
            cand = $signed({3'b000, r_rate});
            code = abc_pkg::DEC_STABLE;
        end

        if (cand < $signed({3'b000, i_cfg.rate_floor})) begin
            n_rate = i_cfg.rate_floor;
        end else if (cand > $signed({3'b000, i_cfg.rate_ceil})) begin
            n_rate = i_cfg.rate_ceil;
        end else begin
            n_rate = cand[abc_pkg::RATE_W-1:0];
        end

        n_last_rise = rise ? i_time : r_last_rise;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= abc_pkg::RATE_CEIL_RST;
            r_last_rise <= '0;
            r_bad       <= '0;
            r_good      <= '0;
        end else if (i_reload.load) begin
            r_rate <= i_reload.rate;
        end else if (i_fire) begin
            r_rate      <= n_rate;
            r_last_rise <= n_last_rise;
            r_bad       <= n_bad;
            r_good      <= n_good;
        end
    end

    // result of this item
    assign o_result.next_bitrate     = n_rate;
    assign o_result.decision_code    = code;
    assign o_result.rate_changed     = (n_rate != r_rate);
    assign o_result.previous_bitrate = r_rate;
    assign o_result.congestion_echo  = i_cong;
    assign o_result.dropped_echo     = i_drop;

endmodule
`default_nettype wire

### rtl/aggressive_bitrate_controller_top.sv
// top level of the bitrate controller: stream ports, item registers, config port
// Takes one measurement interval per item and returns one result item with the
// bitrate for the next interval. Sustained rate is one item per clock while the
// output is not stalled: the item is registered at the input, the decision
// (streak update, a fifth of the rate by reciprocal multiply, hold-off compare
// and clamp) is combinational logic that also closes the rate/streak state
// loop, and the result goes into an output register; a stalled output holds
// one item in the output register and one in the input register before
// s_tready falls. Registers sit at byte addresses 4*i (min, max, decrease
// step, increase step, increase interval); writing max also loads the running
// rate. Configure only while no item is in flight.
`default_nettype none
module aggressive_bitrate_controller_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // congestion_level [11:0], drop count [27:12], time_now [75:28], zero pad
    input  wire logic [abc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // output stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // next_bitrate [17:0], decision_code [19:18], rate_changed [20],
    // previous_bitrate [38:21], congestion_echo [50:39], dropped_echo [66:51], zero pad
    output logic      [abc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [abc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [abc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [abc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    abc_pkg::t_cfg                 cfg;
    abc_pkg::t_reload              reload;
    abc_pkg::t_result              result;

    logic                          r_in_valid;
    logic [abc_pkg::CONG_W-1:0]    r_cong;
    logic [abc_pkg::DROP_W-1:0]    r_drop;
    logic [abc_pkg::TIME_W-1:0]    r_time;
    logic                          r_out_valid;
    abc_pkg::t_result              r_out;

    logic                          advance;
    logic                          fire;
    logic                          s_take;

    // handshake control
    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign s_take     = i_s_tvalid && o_s_tready;

    // config registers
    abc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_reload (reload)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_cong <= i_s_tdata[11:0];
            r_drop <= i_s_tdata[27:12];
            r_time <= i_s_tdata[75:28];
        end
    end

    // decision logic and state
    abc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_reload (reload),
        .i_fire   (fire),
        .i_cong   (r_cong),
        .i_drop   (r_drop),
        .i_time   (r_time),
        .o_result (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(abc_pkg::M_TDATA_W-$bits(abc_pkg::t_result)){1'b0}}, r_out};

endmodule
`default_nettype wire

### rtl/abc_checker.sv
// port-level checks of the bitrate controller and their bind
`default_nettype none
module abc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [abc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input wire logic                            pready
);

    // result item stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result item changed while stalled");

    // changed flag agrees with the two rates it reports
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[20] == (o_m_tdata[17:0] != o_m_tdata[38:21])))
        else $error("rate_changed does not match next and previous rate");

    // no unused decision code ever leaves the block
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[19:18] != 2'd3))
        else $error("illegal decision code");

    // nothing is presented in the first cycle out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind aggressive_bitrate_controller_top abc_checker u_abc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .pready     (pready)
);
`default_nettype wire

### tb/sv/tb_top.sv
// testbench for the bitrate controller: directed table, random interval bursts, self-checking
module tb_top;
    import abc_pkg::*;

    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 6;
    localparam int IDLE_LIMIT      = 3000;
    localparam int N_DIR           = 24;

    typedef enum {RUN_GOOD, RUN_BAD, RUN_MID, RUN_NOISE} t_run_kind;

    // one directed interval, with a hand-typed rate and decision where typed is set
    typedef struct packed {
        logic [CONG_W-1:0] cong;
        logic [DROP_W-1:0] drop;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        t_rate             rate;
        t_decision         code;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // good first interval after reset keeps the start rate
        '{12'd0,    16'd0,     48'd0,    1'b1, 18'd6000, DEC_STABLE},
        // just above half: cut by step plus a fifth
        '{12'd513,  16'd0,     48'd10,   1'b1, 18'd4300, DEC_DECREASE},
        // exactly half is neither good nor bad
        '{12'd512,  16'd0,     48'd20,   1'b1, 18'd4300, DEC_STABLE},
        '{12'd4095, 16'd0,     48'd30,   1'b1, 18'd2940, DEC_DECREASE},
        // drops alone make the interval bad, streak grows
        '{12'd0,    16'd1,     48'd40,   1'b1, 18'd1352, DEC_DECREASE},
        // negative candidate clamps to the minimum
        '{12'd0,    16'd65535, 48'd50,   1'b1, 18'd500,  DEC_DECREASE},
        // streak capped at three, rate already at the floor
        '{12'd4095, 16'd65535, 48'd60,   1'b1, 18'd500,  DEC_DECREASE},
        // just above the good threshold clears both streaks
        '{12'd103,  16'd0,     48'd70,   1'b1, 18'd500,  DEC_STABLE},
        // nine good intervals
        '{12'd102,  16'd0,     48'd100,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd0,    16'd0,     48'd200,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd51,   16'd0,     48'd300,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd1,    16'd0,     48'd400,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd100,  16'd0,     48'd500,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd7,    16'd0,     48'd600,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd64,   16'd0,     48'd700,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd32,   16'd0,     48'd800,  1'b0, 18'd0,    DEC_STABLE},
        '{12'd96,   16'd0,     48'd900,  1'b0, 18'd0,    DEC_STABLE},
        // tenth good one but one time unit short of the hold-off
        '{12'd102,  16'd0,     48'd1999, 1'b1, 18'd500,  DEC_STABLE},
        // hold-off reached: half the increase step
        '{12'd50,   16'd0,     48'd2000, 1'b1, 18'd625,  DEC_INCREASE},
        '{12'd0,    16'd0,     48'd3999, 1'b0, 18'd0,    DEC_STABLE},
        '{12'd0,    16'd0,     48'd4000, 1'b0, 18'd0,    DEC_STABLE},
        // largest timestamp, then elapsed time across the wrap
        '{12'd0,    16'd0,     48'hFFFF_FFFF_FFFF, 1'b0, 18'd0, DEC_STABLE},
        '{12'd0,    16'd0,     48'd1998, 1'b0, 18'd0,    DEC_STABLE},
        '{12'd0,    16'd0,     48'd1999, 1'b0, 18'd0,    DEC_STABLE}
    };

    // clock and dut inputs, all known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                  i_m_tready = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;

    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of registers and state
    t_cfg              cfg_m;
    t_rate             rate_m;
    logic [TIME_W-1:0] last_rise_m;
    logic [BAD_W-1:0]  bad_run;
    logic [GOOD_W-1:0] good_run;

    t_result pending_decisions [$];

    int fail_cnt   = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_reads    = 0;
    int n_rise     = 0;
    int n_fall     = 0;
    int n_steady   = 0;
    int hold_req   = 0;
    int holds_done = 0;
    int hold_left  = 0;
    int gap_left   = 0;
    int calm_left  = 0;

    logic [TIME_W-1:0] ts_now = '0;

    aggressive_bitrate_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void flag_error(string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            flag_error($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // next bitrate and decision for one interval, advances the predictor state
    function automatic t_result decide_rate(logic [CONG_W-1:0] cong, logic [DROP_W-1:0] drop,
                                            logic [TIME_W-1:0] now);
        t_result           r;
        longint            cand;
        logic [TIME_W-1:0] elapsed;
        logic [IVAL_W:0]   need;
        logic              is_bad;
        logic              is_good;
        t_rate             nxt;
        r       = '0;
        is_bad  = (cong > CONG_BAD_ABOVE) || (drop != '0);
        is_good = (cong <= CONG_GOOD_AT_MOST) && (drop == '0);
        cand    = longint'(rate_m);
        r.decision_code = DEC_STABLE;
        if (is_bad) begin
            if (bad_run != BAD_CAP) bad_run++;
            good_run = '0;
            cand = longint'(rate_m) - longint'(cfg_m.decrease_step) * longint'(bad_run)
                 - longint'(rate_m / 5);
            r.decision_code = DEC_DECREASE;
        end else if (is_good) begin
            if (good_run != GOOD_CAP) good_run++;
            bad_run = '0;
            if (good_run >= GOOD_NEEDED) begin
                elapsed = now - last_rise_m;
                need    = {cfg_m.increase_interval, 1'b0};
                if (elapsed >= need) begin
                    cand = cand + longint'(cfg_m.increase_step >> 1);
                    r.decision_code = DEC_INCREASE;
                    last_rise_m = now;
                end
            end
        end else begin
            bad_run  = '0;
            good_run = '0;
        end
        // floor is tested before the ceiling
        if (cand < longint'(cfg_m.rate_floor)) nxt = cfg_m.rate_floor;
        else if (cand > longint'(cfg_m.rate_ceil)) nxt = cfg_m.rate_ceil;
        else nxt = cand[RATE_W-1:0];
        r.next_bitrate     = nxt;
        r.rate_changed     = (nxt != rate_m);
        r.previous_bitrate = rate_m;
        r.congestion_echo  = cong;
        r.dropped_echo     = drop;
        rate_m = nxt;
        return r;
    endfunction

    // one apb transfer: setup, access, then back to idle
    task automatic apb_xfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (wr) begin
            case (idx)
                REG_RATE_FLOOR:        cfg_m.rate_floor = wdata[RATE_W-1:0];
                REG_RATE_CEIL: begin
                    cfg_m.rate_ceil = wdata[RATE_W-1:0];
                    rate_m = wdata[RATE_W-1:0];
                end
                REG_DECREASE_STEP:     cfg_m.decrease_step = wdata[STEP_W-1:0];
                REG_INCREASE_STEP:     cfg_m.increase_step = wdata[STEP_W-1:0];
                REG_INCREASE_INTERVAL: cfg_m.increase_interval = wdata;
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write each narrow register with junk above its width, the interval in full, poke an unused address, read back
    task automatic program_regs(t_rate mn, t_rate mx, logic [STEP_W-1:0] dn,
                                logic [STEP_W-1:0] up, logic [IVAL_W-1:0] iv);
        logic [APB_DATA_W-1:0] w;
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] want;
        w = $urandom; w[RATE_W-1:0] = mn;
        apb_xfer(1'b1, REG_RATE_FLOOR, w, rd);
        w = $urandom; w[RATE_W-1:0] = mx;
        apb_xfer(1'b1, REG_RATE_CEIL, w, rd);
        w = $urandom; w[STEP_W-1:0] = dn;
        apb_xfer(1'b1, REG_DECREASE_STEP, w, rd);
        w = $urandom; w[STEP_W-1:0] = up;
        apb_xfer(1'b1, REG_INCREASE_STEP, w, rd);
        apb_xfer(1'b1, REG_INCREASE_INTERVAL, iv, rd);
        apb_xfer(1'b1, 3'($urandom_range(5, 7)), $urandom, rd);
        for (int i = 0; i <= int'(REG_INCREASE_INTERVAL); i++) begin
            apb_xfer(1'b0, 3'(i), '0, rd);
            want = '0;
            case (3'(i))
                REG_RATE_FLOOR:        want[RATE_W-1:0] = cfg_m.rate_floor;
                REG_RATE_CEIL:         want[RATE_W-1:0] = cfg_m.rate_ceil;
                REG_DECREASE_STEP:     want[STEP_W-1:0] = cfg_m.decrease_step;
                REG_INCREASE_STEP:     want[STEP_W-1:0] = cfg_m.increase_step;
                default:               want = cfg_m.increase_interval;
            endcase
            check_field($sformatf("register %0d readback", i), 64'(want), 64'(rd));
            n_reads++;
        end
    endtask

    // offer one interval and record its expected decision once accepted
    task automatic send_item(logic [CONG_W-1:0] cong, logic [DROP_W-1:0] drop,
                             logic [TIME_W-1:0] stamp, int gap, logic typed,
                             t_rate rate, t_decision code);
        t_result want;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({stamp, drop, cong});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        want = decide_rate(cong, drop, stamp);
        if (typed) begin
            want.next_bitrate  = rate;
            want.decision_code = code;
            want.rate_changed  = (rate != want.previous_bitrate);
        end
        pending_decisions.push_back(want);
        n_sent++;
    endtask

    // stop offering and let every pending result come out
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver pacing: random gaps, calm stretches and the long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (holds_done < hold_req) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(50, 150);
            else gap_left = pick_gap();
        end
    end

    // compare each result with the oldest pending decision
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[$bits(t_result)-1:0];
            if (pending_decisions.size() == 0) begin
                flag_error($sformatf("result with nothing pending, rate %0d", got.next_bitrate));
            end else begin
                want = pending_decisions.pop_front();
                n_checked++;
                check_field("next_bitrate", 64'(want.next_bitrate), 64'(got.next_bitrate));
                check_field("decision_code", 64'(want.decision_code), 64'(got.decision_code));
                check_field("rate_changed", 64'(want.rate_changed), 64'(got.rate_changed));
                check_field("previous_bitrate", 64'(want.previous_bitrate),
                            64'(got.previous_bitrate));
                check_field("congestion_echo", 64'(want.congestion_echo),
                            64'(got.congestion_echo));
                check_field("dropped_echo", 64'(want.dropped_echo), 64'(got.dropped_echo));
                check_field("tdata pad", '0, 64'(o_m_tdata[M_TDATA_W-1:$bits(t_result)]));
                case (want.decision_code)
                    DEC_INCREASE: n_rise++;
                    DEC_DECREASE: n_fall++;
                    default:      n_steady++;
                endcase
            end
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (psel && penable && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int                ph;
        int                sent;
        int                len;
        int                gap;
        t_run_kind         kind;
        logic [CONG_W-1:0] cong;
        logic [DROP_W-1:0] drop;
        logic [TIME_W-1:0] stride;
        t_rate             mn;
        t_rate             mx;
        logic [STEP_W-1:0] dn;
        logic [STEP_W-1:0] up;
        logic [IVAL_W-1:0] iv;
        cfg_m.rate_floor        = RATE_FLOOR_RST;
        cfg_m.rate_ceil         = RATE_CEIL_RST;
        cfg_m.decrease_step     = DECREASE_STEP_RST;
        cfg_m.increase_step     = INCREASE_STEP_RST;
        cfg_m.increase_interval = INCREASE_INTERVAL_RST;
        rate_m      = RATE_CEIL_RST;
        last_rise_m = '0;
        bad_run     = '0;
        good_run    = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table on reset settings
        for (int i = 0; i < N_DIR; i++) begin
            send_item(DIR_ROWS[i].cong, DIR_ROWS[i].drop, DIR_ROWS[i].stamp, pick_gap(),
                      DIR_ROWS[i].typed, DIR_ROWS[i].rate, DIR_ROWS[i].code);
        end
        ts_now = 48'd2000;

        // random bursts, one register setting per phase
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    mn = '0; mx = '1; dn = '1; up = '1; iv = '0;
                end
                1: begin
                    mn = 18'd1000; mx = 18'd200000; dn = 16'd100; up = 16'd2000;
                    iv = 32'd5000;
                end
                2: begin
                    // floor above ceiling
                    mn = '1; mx = '0; dn = '0; up = '0; iv = '1;
                end
                3: begin
                    // half of a one-unit step is zero
                    mn = 18'd3000; mx = 18'd3000; dn = 16'd1; up = 16'd1; iv = 32'd1;
                end
                default: begin
                    mn = RATE_W'($urandom_range(0, 3000));
                    mx = ($urandom_range(0, 4) == 0) ? 18'($urandom_range(0, 262143))
                                                      : 18'(mn + $urandom_range(0, 60000));
                    dn = STEP_W'($urandom_range(0, 3000));
                    up = STEP_W'($urandom_range(0, 10000));
                    iv = ($urandom_range(0, 4) == 0) ? 32'($urandom)
                                                      : 32'($urandom_range(0, 3000));
                end
            endcase
            program_regs(mn, mx, dn, up, iv);
            stride = {15'b0, cfg_m.increase_interval, 1'b0} >> 3;
            if (ph == 1) hold_req++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                len = $urandom_range(0, 99);
                if (len < 45) begin
                    kind = RUN_GOOD;
                    len  = $urandom_range(8, 16);
                end else if (len < 65) begin
                    kind = RUN_BAD;
                    len  = $urandom_range(1, 5);
                end else if (len < 75) begin
                    kind = RUN_MID;
                    len  = $urandom_range(1, 3);
                end else begin
                    kind = RUN_NOISE;
                    len  = $urandom_range(1, 4);
                end
                for (int k = 0; k < len; k++) begin
                    // time mostly advances by an eighth of the hold-off, sometimes jumps
                    if ($urandom_range(0, 9) == 0) begin
                        ts_now = ts_now + {16'($urandom), 32'($urandom)};
                    end else begin
                        ts_now = ts_now + stride + TIME_W'($urandom_range(0, 255));
                    end
                    case (kind)
                        RUN_GOOD: begin
                            cong = CONG_W'($urandom_range(0, CONG_GOOD_AT_MOST));
                            drop = '0;
                        end
                        RUN_BAD: begin
                            if ($urandom_range(0, 1) == 1) begin
                                cong = CONG_W'($urandom_range(CONG_BAD_ABOVE + 1, 4095));
                                drop = ($urandom_range(0, 1) == 1) ? '0
                                                                   : 16'($urandom_range(1, 65535));
                            end else begin
                                cong = CONG_W'($urandom_range(0, 4095));
                                drop = DROP_W'($urandom_range(1, 65535));
                            end
                        end
                        RUN_MID: begin
                            cong = CONG_W'($urandom_range(CONG_GOOD_AT_MOST + 1, CONG_BAD_ABOVE));
                            drop = '0;
                        end
                        default: begin
                            cong   = 12'($urandom);
                            drop   = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom);
                            ts_now = {16'($urandom), 32'($urandom)};
                        end
                    endcase
                    // odd phases open with back-to-back items
                    gap = (ph % 2 == 1 && sent < 40) ? 0 : pick_gap();
                    send_item(cong, drop, ts_now, gap, 1'b0, '0, DEC_STABLE);
                    sent++;
                end
            end
        end
        drain();

        $display("run covered %0d intervals over %0d register settings, %0d results checked",
                 n_sent, N_PHASES + 1, n_checked);
        $display("decisions: %0d increases, %0d decreases, %0d stable; %0d register reads",
                 n_rise, n_fall, n_steady, n_reads);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches in total", fail_cnt);
            $display("FAIL");
        end
        $finish;
    end

endmodule
